// File: rtl/assert_macros.svh
// Assertion macros for the fan tachometer RTL.
// Depends on signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define FTA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds
`define FTA_ASSERT_NEVER(lbl, expr, msg) \
    `FTA_ASSERT(lbl, !(expr), msg)

`endif

// File: rtl/fta_pkg.sv
// Package for the fan tachometer rpm averager: constants, config and lane types.
// No dependencies.
package fta_pkg;

    localparam int FAN_CHANNELS_DEF  = 4;
    localparam int AVERAGE_DEPTH_DEF = 8;

    localparam int RPM_W     = 25;
    localparam int SUM_W     = 32;
    localparam int WAIT_W    = 24;
    localparam int SPR_W     = 8;
    localparam int DIVN_W    = 32;
    localparam int DIVD_W    = 40;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    localparam logic [DIVN_W-1:0] RPM_NUMERATOR = DIVN_W'(60000000);
    localparam logic [WAIT_W-1:0] WAIT_MAX      = {WAIT_W{1'b1}};

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLES  = 3'd0,
        REG_PPR      = 3'd1,
        REG_POLES    = 3'd2,
        REG_TIMEOUT  = 3'd3,
        REG_INTERVAL = 3'd4
    } cfg_reg_t;

    localparam logic [7:0]  SPR_RST      = 8'd4;
    localparam logic [3:0]  PPR_RST      = 4'd2;
    localparam logic [4:0]  POLES_RST    = 5'd1;
    localparam logic [19:0] TIMEOUT_RST  = 20'd200000;
    localparam logic [23:0] INTERVAL_RST = 24'd500000;

    typedef struct packed {
        logic [7:0]  spr;
        logic [3:0]  ppr;
        logic [4:0]  poles;
        logic [19:0] timeout;
        logic [23:0] interval;
    } cfg_t;

    // What a lane hands the merging stage after each tick
    typedef struct packed {
        logic             done;
        logic             timed_out;
        logic [SUM_W-1:0] sum;
    } lane_stat_t;

endpackage

// File: rtl/fan_tachometer_rpm_averager_unit.sv
// Fan tachometer rpm averager: FAN_CHANNELS lanes time tacho low pulses on each
// one-microsecond input item, and a merging stage turns each finished reading into
// raw and moving-average rpm through one shared 32-step restoring divider. Each
// finished reading takes up to three divisions (sum by samples, 60000000 by pulse
// period, by poles; none when a pulse timed out or the sample count is zero, only
// the first when the period is zero). The moving average is a shift when
// AVERAGE_DEPTH is a power of two and one more division otherwise; the first reading
// of a lane instead fills its whole history with the raw value. Results leave in lane
// order, the final one of an item with tlast set; the next item is accepted once all
// are taken.
// Depends on fta_pkg, fta_lane, fta_div and fta_merge.
module fan_tachometer_rpm_averager_unit
    import fta_pkg::*;
#(
    parameter int FAN_CHANNELS  = FAN_CHANNELS_DEF,
    parameter int AVERAGE_DEPTH = AVERAGE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // tacho_levels[3:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [55:0]          m_tdata,   // fan_index, raw_rpm, average_rpm, timed_out
    output logic                 m_tlast,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    cfg_t             cfg_reg;
    lane_stat_t       stat [FAN_CHANNELS];
    logic             tick;
    logic [1:0]       fan_index;
    logic [RPM_W-1:0] raw_rpm, average_rpm;
    logic             timed_out;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spr      <= SPR_RST;
            cfg_reg.ppr      <= PPR_RST;
            cfg_reg.poles    <= POLES_RST;
            cfg_reg.timeout  <= TIMEOUT_RST;
            cfg_reg.interval <= INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SAMPLES:  cfg_reg.spr      <= cfg_data[7:0];
                REG_PPR:      cfg_reg.ppr      <= cfg_data[3:0];
                REG_POLES:    cfg_reg.poles    <= cfg_data[4:0];
                REG_TIMEOUT:  cfg_reg.timeout  <= cfg_data[19:0];
                REG_INTERVAL: cfg_reg.interval <= cfg_data;
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    assign tick = s_tvalid && s_tready;

    // One timing lane per fan
    for (genvar g = 0; g < FAN_CHANNELS; g++)
    begin : g_lane
        fta_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .tick  (tick),
            .level (s_tdata[g]),
            .cfg   (cfg_reg),
            .stat  (stat[g])
        );
    end

    fta_merge #(
        .FAN_CHANNELS  (FAN_CHANNELS),
        .AVERAGE_DEPTH (AVERAGE_DEPTH)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .stat         (stat),
        .cfg          (cfg_reg),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .fan_index    (fan_index),
        .raw_rpm      (raw_rpm),
        .average_rpm  (average_rpm),
        .timed_out    (timed_out),
        .last_of_tick (m_tlast)
    );

    // Pack result fields from the lowest bit up
    assign m_tdata = {3'b000, timed_out, average_rpm, raw_rpm, fan_index};

endmodule

// File: rtl/fta_lane.sv
// One fan lane: times tacho low pulses and flags a finished reading.
// Depends on fta_pkg.
module fta_lane
    import fta_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick,
    input  logic       level,
    input  cfg_t       cfg,
    output lane_stat_t stat
);

    typedef enum logic [4:0] {
        PH_EDGE_SKIP = 5'b00001,
        PH_LOW_SKIP  = 5'b00010,
        PH_EDGE_CNT  = 5'b00100,
        PH_LOW_CNT   = 5'b01000,
        PH_IDLE      = 5'b10000
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic              prev_reg;
    logic [WAIT_W-1:0] wait_reg, wait_next, wait_inc;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SPR_W-1:0]  smp_reg, smp_next;
    logic              done_reg, done_next, to_reg, to_next;
    logic              finish;

    assign wait_inc = (wait_reg != WAIT_MAX) ? wait_reg + 1'b1 : wait_reg;

    // Advance the pulse timer by one tick
    always_comb
    begin
        phase_next = phase_reg;
        wait_next  = wait_inc;
        sum_next   = sum_reg;
        smp_next   = smp_reg;
        done_next  = 1'b0;
        to_next    = 1'b0;
        finish     = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (wait_inc >= cfg.interval)
                begin
                    phase_next = PH_EDGE_SKIP;
                    wait_next  = '0;
                end
            end
            PH_LOW_SKIP, PH_LOW_CNT:
            begin
                if (!level)
                begin
                    if (phase_reg == PH_LOW_CNT)
                        sum_next = sum_reg + 1'b1;
                    if (wait_inc >= WAIT_W'(cfg.timeout))
                    begin
                        finish  = 1'b1;
                        to_next = 1'b1;
                    end
                end
                else
                begin
                    wait_next  = '0;
                    phase_next = PH_EDGE_CNT;
                    if (phase_reg == PH_LOW_CNT)
                        smp_next = smp_reg + 1'b1;
                    else
                    begin
                        sum_next = '0;
                        smp_next = '0;
                    end
                    if (smp_next >= cfg.spr)
                        finish = 1'b1;
                end
            end
            default:
            begin
                // Edge phases; unknown codes behave as the skip edge
                if (prev_reg && !level)
                begin
                    if (phase_reg == PH_EDGE_CNT)
                    begin
                        sum_next   = sum_reg + 1'b1;
                        phase_next = PH_LOW_CNT;
                    end
                    else
                        phase_next = PH_LOW_SKIP;
                end
                else if (phase_reg != PH_EDGE_CNT)
                    phase_next = PH_EDGE_SKIP;
                if (wait_inc >= WAIT_W'(cfg.timeout))
                begin
                    finish  = 1'b1;
                    to_next = 1'b1;
                end
            end
        endcase
        if (finish)
        begin
            done_next  = 1'b1;
            wait_next  = '0;
            phase_next = (cfg.interval == '0) ? PH_EDGE_SKIP : PH_IDLE;
        end
    end

    // Hold lane state between ticks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_EDGE_SKIP;
            prev_reg  <= 1'b1;
            wait_reg  <= '0;
            sum_reg   <= '0;
            smp_reg   <= '0;
            done_reg  <= 1'b0;
            to_reg    <= 1'b0;
        end
        else if (tick)
        begin
            phase_reg <= phase_next;
            prev_reg  <= level;
            wait_reg  <= wait_next;
            sum_reg   <= sum_next;
            smp_reg   <= smp_next;
            done_reg  <= done_next;
            to_reg    <= to_next;
        end
    end

    assign stat.done      = done_reg;
    assign stat.timed_out = to_reg;
    assign stat.sum       = sum_reg;

endmodule

// File: rtl/fta_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on fta_pkg.
module fta_div
    import fta_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVN_W-1:0] dividend,
    input  logic [DIVD_W-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [DIVN_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVN_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [DIVN_W-1:0] quo_reg;
    logic [DIVD_W-1:0] rem_reg, den_reg;
    logic [DIVD_W:0]   trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[DIVN_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    // Count iterations and flag the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start)
                cnt_reg <= CNT_W'(DIVN_W);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Shift in one dividend bit, subtract where it fits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DIVN_W-2:0], fits};
            rem_reg <= fits ? DIVD_W'(trial - {1'b0, den_reg}) : trial[DIVD_W-1:0];
        end
    end

    assign busy     = cnt_reg != '0;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/fta_merge.sv
// Merging stage: walks finished lanes in order, computes rpm and the moving average.
// Depends on fta_pkg, fta_div and assert_macros.svh.
`include "assert_macros.svh"
module fta_merge
    import fta_pkg::*;
#(
    parameter int FAN_CHANNELS  = FAN_CHANNELS_DEF,
    parameter int AVERAGE_DEPTH = AVERAGE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  lane_stat_t       stat [FAN_CHANNELS],
    input  cfg_t             cfg,
    input  logic             out_ready,
    output logic             out_valid,
    output logic [1:0]       fan_index,
    output logic [RPM_W-1:0] raw_rpm,
    output logic [RPM_W-1:0] average_rpm,
    output logic             timed_out,
    output logic             last_of_tick
);

    localparam int LW   = (FAN_CHANNELS > 1) ? $clog2(FAN_CHANNELS) : 1;
    localparam int SW   = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
    localparam int SH   = $clog2(AVERAGE_DEPTH);
    localparam int HS_W = RPM_W + $clog2(AVERAGE_DEPTH + 1);
    localparam int PR_W = DIVN_W + 4;
    localparam bit DEPTH_POW2 = (AVERAGE_DEPTH & (AVERAGE_DEPTH - 1)) == 0;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_CAP   = 13'b0000000000010,
        ST_SCAN  = 13'b0000000000100,
        ST_START = 13'b0000000001000,
        ST_DIVA  = 13'b0000000010000,
        ST_MUL   = 13'b0000000100000,
        ST_DIVB  = 13'b0000001000000,
        ST_DIVC  = 13'b0000010000000,
        ST_HIST  = 13'b0000100000000,
        ST_FILL  = 13'b0001000000000,
        ST_READ  = 13'b0010000000000,
        ST_UPD   = 13'b0100000000000,
        ST_DIVD  = 13'b1000000000000
    } mst_t;

    mst_t                    state_reg, state_next;
    logic                    out_valid_reg, out_valid_next;
    logic [FAN_CHANNELS-1:0] pend_reg, pend_next, done_vec;
    logic [LW-1:0]           cur_reg, cur_next, low_idx;
    logic                    div_start_reg, div_start_next;
    logic [HS_W-1:0]         hsum_reg [FAN_CHANNELS];
    logic [SW-1:0]           slot_reg [FAN_CHANNELS];
    logic                    primed_reg [FAN_CHANNELS];

    logic                    last_reg, to_reg;
    logic [RPM_W-1:0]        raw_reg, avg_reg, rd_reg;
    logic [PR_W-1:0]         prod_reg;
    logic [PR_W:0]           full;
    logic [SW-1:0]           fill_reg;
    logic [DIVN_W-1:0]       div_a_reg, div_q;
    logic [DIVD_W-1:0]       div_b_reg;
    logic                    div_busy, div_done;
    logic [HS_W-1:0]         hsum_new;
    logic                    fill_end;

    logic [RPM_W-1:0]        hist_mem [FAN_CHANNELS][AVERAGE_DEPTH];

    fta_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_a_reg),
        .divisor  (div_b_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // Gather done flags and pick the lowest pending lane
    always_comb
    begin
        low_idx = '0;
        for (int i = 0; i < FAN_CHANNELS; i++)
            done_vec[i] = stat[i].done;
        for (int i = FAN_CHANNELS - 1; i >= 0; i--)
            if (pend_reg[i])
                low_idx = LW'(i);
    end

    assign full     = {prod_reg, 1'b0};
    assign fill_end = fill_reg == SW'(AVERAGE_DEPTH - 1);
    assign hsum_new = hsum_reg[cur_reg] - HS_W'(rd_reg) + HS_W'(raw_reg);

    // Sequence one reading at a time through the shared divider
    always_comb
    begin
        state_next     = state_reg;
        pend_next      = pend_reg;
        cur_next       = cur_reg;
        div_start_next = 1'b0;
        out_valid_next = out_valid_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_CAP;
            ST_CAP:
            begin
                pend_next  = done_vec;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (out_valid_reg)
                begin
                    if (out_ready)
                        out_valid_next = 1'b0;
                end
                else if (pend_reg == '0)
                    state_next = ST_IDLE;
                else
                begin
                    cur_next  = low_idx;
                    pend_next = pend_reg & ~(FAN_CHANNELS'(1) << low_idx);
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (stat[cur_reg].timed_out || cfg.spr == '0)
                    state_next = ST_HIST;
                else
                begin
                    div_start_next = 1'b1;
                    state_next     = ST_DIVA;
                end
            end
            ST_DIVA:
                if (div_done)
                    state_next = ST_MUL;
            ST_MUL:
            begin
                if (full == '0)
                    state_next = ST_HIST;
                else
                begin
                    div_start_next = 1'b1;
                    state_next     = ST_DIVB;
                end
            end
            ST_DIVB:
                if (div_done)
                begin
                    div_start_next = 1'b1;
                    state_next     = ST_DIVC;
                end
            ST_DIVC:
                if (div_done)
                    state_next = ST_HIST;
            ST_HIST:
                state_next = primed_reg[cur_reg] ? ST_READ : ST_FILL;
            ST_FILL:
                // A filled history averages to the raw value itself
                if (fill_end)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_SCAN;
                end
            ST_READ:
                state_next = ST_UPD;
            ST_UPD:
            begin
                if (DEPTH_POW2)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    div_start_next = 1'b1;
                    state_next     = ST_DIVD;
                end
            end
            ST_DIVD:
                if (div_done)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_SCAN;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Hold control state and per-lane averaging state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pend_reg      <= '0;
            cur_reg       <= '0;
            div_start_reg <= 1'b0;
            for (int i = 0; i < FAN_CHANNELS; i++)
            begin
                hsum_reg[i]   <= '0;
                slot_reg[i]   <= '0;
                primed_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            cur_reg       <= cur_next;
            div_start_reg <= div_start_next;
            if (state_reg == ST_FILL && fill_end)
            begin
                hsum_reg[cur_reg]   <= HS_W'(raw_reg) * HS_W'(AVERAGE_DEPTH);
                slot_reg[cur_reg]   <= '0;
                primed_reg[cur_reg] <= 1'b1;
            end
            else if (state_reg == ST_UPD)
            begin
                hsum_reg[cur_reg] <= hsum_new;
                slot_reg[cur_reg] <= (slot_reg[cur_reg] == SW'(AVERAGE_DEPTH - 1)) ?
                                     '0 : slot_reg[cur_reg] + 1'b1;
            end
        end
    end

    // Load divider operands and capture results
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_START:
            begin
                last_reg  <= pend_reg == '0;
                to_reg    <= stat[cur_reg].timed_out;
                raw_reg   <= '0;
                div_a_reg <= stat[cur_reg].sum;
                div_b_reg <= DIVD_W'(cfg.spr);
            end
            ST_DIVA:
                prod_reg <= PR_W'(div_q) * PR_W'(cfg.ppr);
            ST_MUL:
            begin
                div_a_reg <= RPM_NUMERATOR;
                div_b_reg <= DIVD_W'(full);
            end
            ST_DIVB:
            begin
                div_a_reg <= div_q;
                div_b_reg <= (cfg.poles == '0) ? DIVD_W'(1) : DIVD_W'(cfg.poles);
            end
            ST_DIVC:
                raw_reg <= div_q[RPM_W-1:0];
            ST_HIST:
                fill_reg <= '0;
            ST_FILL:
            begin
                fill_reg <= fill_reg + 1'b1;
                avg_reg  <= raw_reg;
            end
            ST_UPD:
            begin
                // Power-of-two depth divides by a shift
                avg_reg   <= RPM_W'(hsum_new >> SH);
                div_a_reg <= DIVN_W'(hsum_new);
                div_b_reg <= DIVD_W'(AVERAGE_DEPTH);
            end
            ST_DIVD:
                avg_reg <= div_q[RPM_W-1:0];
            default:
                prod_reg <= prod_reg;
        endcase
    end

    // History memory: one write port, one registered read
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FILL)
            hist_mem[cur_reg][fill_reg] <= raw_reg;
        else if (state_reg == ST_UPD)
            hist_mem[cur_reg][slot_reg[cur_reg]] <= raw_reg;
        rd_reg <= hist_mem[cur_reg][slot_reg[cur_reg]];
    end

    assign in_ready     = state_reg == ST_IDLE;
    assign out_valid    = out_valid_reg;
    assign fan_index    = 2'(cur_reg);
    assign raw_rpm      = raw_reg;
    assign average_rpm  = avg_reg;
    assign timed_out    = to_reg;
    assign last_of_tick = last_reg;

    `FTA_ASSERT_NEVER(a_ready_while_out, in_ready && out_valid_reg, "input taken with result pending")
    `FTA_ASSERT_NEVER(a_div_overlap, div_start_reg && div_busy, "divider restarted while busy")
    `FTA_ASSERT(a_timeout_zero, out_valid_reg && to_reg |-> raw_reg == '0, "timeout with nonzero rpm")
    `FTA_ASSERT(a_primed_after_fill, state_reg == ST_FILL && fill_end |=> primed_reg[cur_reg], "history not primed")

endmodule
